[hdl/bfks_pkg.sv]
// ----------------------------------------------------------------------------
// bfks_pkg: shared definitions for the bounded FIFO with key search
// Widths, reset values, operation and result codes, controller states and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package bfks_pkg;

	// Built-in store depth used when the top level is not overridden.
	localparam int unsigned DEPTH_DEF = 16;

	// Fixed field widths.
	localparam int unsigned ACT_W = 2;
	localparam int unsigned VAL_W = 32;
	localparam int unsigned STS_W = 3;
	localparam int unsigned CNT_W = 5;

	// Capacity register value after reset.
	localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

	// Requested operation of one input beat.
	typedef enum logic [ACT_W-1:0] {
		ACT_ENQ  = 2'd0,
		ACT_DEQ  = 2'd1,
		ACT_FIND = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	// Result status codes.
	typedef enum logic [STS_W-1:0] {
		STS_ENQ   = 3'd0,
		STS_OVF   = 3'd1,
		STS_DEQ   = 3'd2,
		STS_EMPTY = 3'd3,
		STS_FOUND = 3'd4,
		STS_MISS  = 3'd5
	} status_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_DEQ_WAIT,
		S_SCAN_RD,
		S_SCAN_CMP
	} state_t;

	// Source of the result item field.
	typedef enum logic [1:0] {
		ITEM_KEY,
		ITEM_ZERO,
		ITEM_MEM
	} item_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      cmd_load;    // capture the accepted input beat
		logic      rd_en;       // read the store, data valid next cycle
		logic      rd_at_head;  // read address is the head, else the scan pointer
		logic      scan_init;   // start a scan at the head
		logic      scan_step;   // advance the scan pointer
		logic      commit_enq;  // write at the tail and grow the queue
		logic      commit_deq;  // drop the head and shrink the queue
		logic      res_load;    // load the output register
		status_t   res_status;
		item_sel_t res_item;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		action_t action;     // operation of the captured beat
		logic    can_enq;    // count is below the effective capacity
		logic    empty;      // no items held
		logic    out_free;   // output register can take a result this cycle
		logic    match;      // read data equals the key
		logic    scan_last;  // the entry under compare is the tail entry
	} dp_stat_t;

endpackage

[hdl/bfks_ctrl.sv]
// ----------------------------------------------------------------------------
// bfks_ctrl: operation sequencer
// Accepts one input beat at a time, steps the datapath through enqueue,
// dequeue or a head-to-tail key scan, and hands the result to the output
// register when it is free.
// ----------------------------------------------------------------------------
module bfks_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bfks_pkg::dp_stat_t st,
	output bfks_pkg::ctl_t     ctl
);
	import bfks_pkg::*;

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		ctl            = '0;
		ctl.res_status = STS_MISS;
		ctl.res_item   = ITEM_KEY;

		unique case (state_q)
			S_IDLE: begin
				in_ready     = 1'b1;
				ctl.cmd_load = in_valid;
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end

			S_EXEC: begin
				unique case (st.action)
					ACT_ENQ: begin
						if (st.out_free) begin
							ctl.res_load   = 1'b1;
							ctl.res_status = st.can_enq ? STS_ENQ : STS_OVF;
							ctl.commit_enq = st.can_enq;
							state_d        = S_IDLE;
						end
					end
					ACT_DEQ: begin
						if (st.empty) begin
							if (st.out_free) begin
								ctl.res_load   = 1'b1;
								ctl.res_status = STS_EMPTY;
								ctl.res_item   = ITEM_ZERO;
								state_d        = S_IDLE;
							end
						end else begin
							ctl.rd_en      = 1'b1;
							ctl.rd_at_head = 1'b1;
							state_d        = S_DEQ_WAIT;
						end
					end
					ACT_FIND: begin
						if (st.empty) begin
							if (st.out_free) begin
								ctl.res_load   = 1'b1;
								ctl.res_status = STS_MISS;
								state_d        = S_IDLE;
							end
						end else begin
							ctl.scan_init = 1'b1;
							state_d       = S_SCAN_RD;
						end
					end
					ACT_NONE: begin
						// Unused code: no state change, reported as not found.
						if (st.out_free) begin
							ctl.res_load   = 1'b1;
							ctl.res_status = STS_MISS;
							state_d        = S_IDLE;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end

			S_DEQ_WAIT: begin
				// Head entry is in the read register; it holds until taken.
				if (st.out_free) begin
					ctl.res_load   = 1'b1;
					ctl.res_status = STS_DEQ;
					ctl.res_item   = ITEM_MEM;
					ctl.commit_deq = 1'b1;
					state_d        = S_IDLE;
				end
			end

			S_SCAN_RD: begin
				ctl.rd_en = 1'b1;
				state_d   = S_SCAN_CMP;
			end

			S_SCAN_CMP: begin
				if (st.match || st.scan_last) begin
					if (st.out_free) begin
						ctl.res_load   = 1'b1;
						ctl.res_status = st.match ? STS_FOUND : STS_MISS;
						state_d        = S_IDLE;
					end
				end else begin
					ctl.scan_step = 1'b1;
					state_d       = S_SCAN_RD;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[hdl/bfks_dp.sv]
// ----------------------------------------------------------------------------
// bfks_dp: queue datapath
// Holds the item store, head and tail pointers, item count, capacity
// register, captured input beat, scan pointer and the output register.
// ----------------------------------------------------------------------------
module bfks_dp #(
	parameter int unsigned DEPTH = bfks_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bfks_pkg::ctl_t                    ctl,
	output bfks_pkg::dp_stat_t                st,
	input  logic [bfks_pkg::ACT_W-1:0]        in_action,
	input  logic signed [bfks_pkg::VAL_W-1:0] in_value,
	input  logic                              cfg_we,
	input  logic [bfks_pkg::CNT_W-1:0]        cfg_wdata,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [bfks_pkg::STS_W-1:0]        out_status,
	output logic signed [bfks_pkg::VAL_W-1:0] out_item,
	output logic [bfks_pkg::CNT_W-1:0]        out_count
);
	import bfks_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

	logic [VAL_W-1:0] store_mem [DEPTH];
	logic [VAL_W-1:0] rd_data_q;
	logic [AW-1:0]    rd_addr;

	logic [AW-1:0]    head_q, tail_q, scan_pos_q;
	logic [CNT_W-1:0] count_q, scan_k_q, count_next;
	logic [CNT_W-1:0] cap_q;
	action_t          act_q;
	logic [VAL_W-1:0] key_q;

	logic             out_valid_q;
	logic [STS_W-1:0] out_status_q;
	logic [VAL_W-1:0] out_item_q;
	logic [CNT_W-1:0] out_count_q;
	logic [VAL_W-1:0] res_item;

	// Circular increment of a store index.
	function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] idx);
		return (idx == LAST_SLOT) ? '0 : idx + 1'b1;
	endfunction

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// Captured input beat.
	always_ff @(posedge clk) begin
		if (ctl.cmd_load) begin
			act_q <= action_t'(in_action);
			key_q <= in_value;
		end
	end

	// Item store: one write port at the tail, one registered read port.
	assign rd_addr = ctl.rd_at_head ? head_q : scan_pos_q;

	always_ff @(posedge clk) begin
		if (ctl.commit_enq) begin
			store_mem[tail_q] <= key_q;
		end
		if (ctl.rd_en) begin
			rd_data_q <= store_mem[rd_addr];
		end
	end

	// Queue pointers and item count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (ctl.commit_enq) begin
				tail_q <= next_slot(tail_q);
			end
			if (ctl.commit_deq) begin
				head_q <= next_slot(head_q);
			end
			count_q <= count_next;
		end
	end

	always_comb begin
		count_next = count_q;
		if (ctl.commit_enq) begin
			count_next = count_q + 1'b1;
		end else if (ctl.commit_deq) begin
			count_next = count_q - 1'b1;
		end
	end

	// Scan pointer and number of entries already passed.
	always_ff @(posedge clk) begin
		if (ctl.scan_init) begin
			scan_pos_q <= head_q;
			scan_k_q   <= '0;
		end else if (ctl.scan_step) begin
			scan_pos_q <= next_slot(scan_pos_q);
			scan_k_q   <= scan_k_q + 1'b1;
		end
	end

	// Output register; it frees up in the same cycle its beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		unique case (ctl.res_item)
			ITEM_ZERO: res_item = '0;
			ITEM_MEM:  res_item = rd_data_q;
			default:   res_item = key_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.res_load) begin
			out_status_q <= ctl.res_status;
			out_item_q   <= res_item;
			out_count_q  <= count_next;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_item   = out_item_q;
	assign out_count  = out_count_q;

	// Status toward the controller. The effective capacity is the register
	// value capped at the store depth.
	always_comb begin
		st.action    = act_q;
		st.can_enq   = (count_q < cap_q) && (32'(count_q) < 32'(DEPTH));
		st.empty     = (count_q == '0);
		st.out_free  = !out_valid_q || out_ready;
		st.match     = (rd_data_q == key_q);
		st.scan_last = ((scan_k_q + 1'b1) == count_q);
	end

endmodule

[hdl/bounded_fifo_with_key_search.sv]
// ----------------------------------------------------------------------------
// bounded_fifo_with_key_search: FIFO of signed 32-bit items with key search
// The block takes one operation beat at a time and returns exactly one result
// beat for it. Enqueue and overflow results go to the output register
// straight from the execute state, dequeue results after a registered read
// of the head entry, and a key search compares entries from the head toward
// the tail, up to the item count, stopping at the first match: each entry
// takes a registered store read and then a compare. The next input beat is
// taken as soon as the previous operation has handed its result to the output
// register, even if that result has not yet been taken. The capacity register
// may be written only while no operation is in flight; values above DEPTH act
// as DEPTH and zero makes every enqueue overflow.
// ----------------------------------------------------------------------------
module bounded_fifo_with_key_search #(
	parameter int unsigned DEPTH = bfks_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [bfks_pkg::ACT_W-1:0]        action,
	input  logic signed [bfks_pkg::VAL_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [bfks_pkg::STS_W-1:0]        status,
	output logic signed [bfks_pkg::VAL_W-1:0] item,
	output logic [bfks_pkg::CNT_W-1:0]        count,
	input  logic                              cfg_we,
	input  logic [bfks_pkg::CNT_W-1:0]        cfg_wdata
);
	import bfks_pkg::*;

	ctl_t     ctl;
	dp_stat_t st;

	// Operation sequencer.
	bfks_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.ctl      (ctl)
	);

	// Store, pointers and output register.
	bfks_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.st         (st),
		.in_action  (action),
		.in_value   (value),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_status (status),
		.out_item   (item),
		.out_count  (count)
	);

endmodule

[verif/tb_bounded_fifo_with_key_search.sv]
// ----------------------------------------------------------------------------
// tb_bounded_fifo_with_key_search: self-checking bench for the searchable FIFO
// A short table of directed operations with hand-written results comes first.
// A fill-and-drain pass at a saturating capacity follows, then random phases
// at several capacities. Each phase mixes enqueue, dequeue and find with keys
// that are often taken from the queue. A behavioral copy of the queue
// predicts every result beat, and the bench compares the beats in order.
// Both sides idle at random, and the receiver also stalls once for a long time.
// ----------------------------------------------------------------------------
module tb_bounded_fifo_with_key_search;
	import bfks_pkg::*;

	localparam int unsigned DEPTH            = DEPTH_DEF;
	localparam int unsigned SETTLE_CYCLES    = 2 * DEPTH + 8;
	localparam int unsigned LONG_HOLD_CYCLES = 150;
	localparam int unsigned PHASE_ITEMS      = 110;
	localparam int unsigned NUM_PHASES       = 8;
	localparam int unsigned MAX_CYCLES       = 400000;
	localparam int unsigned REPORT_LIMIT     = 10;

	// One result beat as the block returns it.
	typedef struct packed {
		status_t            st;
		logic [VAL_W-1:0]   itm;
		logic [CNT_W-1:0]   cnt;
	} fifo_result_t;

	// One directed step: either a capacity write or an operation beat.
	typedef struct packed {
		logic               wr_cap;
		logic [CNT_W-1:0]   cap;
		action_t            act;
		logic [VAL_W-1:0]   val;
		logic               pinned;
		fifo_result_t       res;
	} dir_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [ACT_W-1:0]       action = ACT_ENQ;
	logic signed [VAL_W-1:0] value = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [STS_W-1:0]       status;
	logic signed [VAL_W-1:0] item;
	logic [CNT_W-1:0]       count;
	logic                   cfg_we = 1'b0;
	logic [CNT_W-1:0]       cfg_wdata = CAP_RESET;

	// A hand-written result travels with its input beat.
	logic                   exp_pinned = 1'b0;
	fifo_result_t           pinned_res = '0;

	// Behavioral copy of the queue and its capacity register.
	logic [VAL_W-1:0]       mirror_store [DEPTH] = '{default: '0};
	int unsigned            mirror_head = 0;
	int unsigned            mirror_tail = 0;
	int unsigned            mirror_count = 0;
	int unsigned            mirror_cap = CAP_RESET;

	fifo_result_t           awaited_results [$];
	int unsigned            mismatch_count = 0;
	bit                     hold_pending = 1'b0;
	bit                     calm = 1'b0;

	bounded_fifo_with_key_search #(
		.DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.item(item),
		.count(count),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	// Applies one operation to the queue copy and returns the result it yields.
	function automatic fifo_result_t apply_queue_op(action_t a, logic [VAL_W-1:0] v);
		fifo_result_t r;
		int unsigned lim;
		int unsigned pos;
		r.st = STS_MISS;
		r.itm = v;
		lim = (mirror_cap > DEPTH) ? DEPTH : mirror_cap;
		case (a)
			ACT_ENQ: begin
				if (mirror_count < lim) begin
					mirror_store[mirror_tail] = v;
					mirror_tail = (mirror_tail + 1) % DEPTH;
					mirror_count++;
					r.st = STS_ENQ;
				end else begin
					r.st = STS_OVF;
				end
			end
			ACT_DEQ: begin
				if (mirror_count == 0) begin
					r.st = STS_EMPTY;
					r.itm = '0;
				end else begin
					r.itm = mirror_store[mirror_head];
					mirror_head = (mirror_head + 1) % DEPTH;
					mirror_count--;
					r.st = STS_DEQ;
				end
			end
			ACT_FIND: begin
				pos = mirror_head;
				for (int k = 0; k < mirror_count; k++) begin
					if (mirror_store[pos] == v)
						r.st = STS_FOUND;
					pos = (pos + 1) % DEPTH;
				end
			end
			default: ;
		endcase
		r.cnt = CNT_W'(mirror_count);
		return r;
	endfunction

	// A random operand: often small, sometimes an extreme, else any pattern.
	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2: return VAL_W'($urandom_range(0, 7)) - VAL_W'(4);
			3:       return 32'h8000_0000;
			4:       return 32'h7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic dir_row_t cap_row(logic [CNT_W-1:0] c);
		dir_row_t row;
		row = '0;
		row.wr_cap = 1'b1;
		row.cap = c;
		return row;
	endfunction

	function automatic dir_row_t typed_row(action_t a, logic [VAL_W-1:0] v, status_t s,
			logic [VAL_W-1:0] i, int unsigned c);
		dir_row_t row;
		row = '0;
		row.act = a;
		row.val = v;
		row.pinned = 1'b1;
		row.res.st = s;
		row.res.itm = i;
		row.res.cnt = CNT_W'(c);
		return row;
	endfunction

	// Watches both channels and the register port at every rising edge.
	always @(posedge clk) begin : beat_monitor
		fifo_result_t got;
		fifo_result_t want;
		fifo_result_t pred;
		if (arst_n) begin
			if (cfg_we)
				mirror_cap = cfg_wdata;
			if (out_valid && out_ready) begin
				got.st = status_t'(status);
				got.itm = item;
				got.cnt = count;
				if (awaited_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("unexpected result beat: status %0d item %0d count %0d",
							got.st, $signed(got.itm), got.cnt);
				end else begin
					want = awaited_results.pop_front();
					if (got !== want) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT)
							$display("mismatch: expected status %0d item %0d count %0d, got status %0d item %0d count %0d",
								want.st, $signed(want.itm), want.cnt,
								got.st, $signed(got.itm), got.cnt);
					end
				end
			end
			if (in_valid && in_ready) begin
				pred = apply_queue_op(action_t'(action), value);
				awaited_results.push_back(exp_pinned ? pinned_res : pred);
			end
		end
	end

	// Receiver: ready runs, random stalls, and one long hold-off on request.
	initial begin : receiver
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_pending) begin
				hold_pending = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		#(MAX_CYCLES * 12);
		$display("FAIL bounded_fifo_with_key_search");
		$finish;
	end

	// Presents one beat and returns at the edge where it is taken.
	task automatic offer_beat(input action_t a, input logic [VAL_W-1:0] v,
			input logic pinned, input fifo_result_t pres);
		in_valid <= 1'b1;
		action <= a;
		value <= v;
		exp_pinned <= pinned;
		pinned_res <= pres;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic maybe_idle(input int unsigned pct);
		if (!calm && $urandom_range(0, 99) < pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	// Stops sending and waits until every predicted beat has come back.
	task automatic wait_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cap(input logic [CNT_W-1:0] c);
		cfg_we <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		dir_row_t           dir_tab [$];
		logic [CNT_W-1:0]   phase_caps [NUM_PHASES];
		logic [VAL_W-1:0]   v;
		logic [VAL_W-1:0]   first_val;
		logic [VAL_W-1:0]   last_val;
		action_t            a;
		int unsigned        idle_pct;
		int unsigned        enq_w;
		int unsigned        r;

		// Empty queue, then extremes, every operation and the unused code.
		dir_tab.push_back(typed_row(ACT_DEQ, 32'h0000_1234, STS_EMPTY, '0, 0));
		dir_tab.push_back(typed_row(ACT_FIND, 32'd5, STS_MISS, 32'd5, 0));
		dir_tab.push_back(typed_row(ACT_NONE, 32'h7fff_ffff, STS_MISS, 32'h7fff_ffff, 0));
		dir_tab.push_back(typed_row(ACT_ENQ, 32'h8000_0000, STS_ENQ, 32'h8000_0000, 1));
		dir_tab.push_back(typed_row(ACT_ENQ, 32'h7fff_ffff, STS_ENQ, 32'h7fff_ffff, 2));
		dir_tab.push_back(typed_row(ACT_ENQ, 32'hffff_ffff, STS_ENQ, 32'hffff_ffff, 3));
		dir_tab.push_back(typed_row(ACT_ENQ, 32'h0, STS_ENQ, 32'h0, 4));
		dir_tab.push_back(typed_row(ACT_FIND, 32'hffff_ffff, STS_FOUND, 32'hffff_ffff, 4));
		dir_tab.push_back(typed_row(ACT_FIND, 32'h7fff_ffff, STS_FOUND, 32'h7fff_ffff, 4));
		dir_tab.push_back(typed_row(ACT_FIND, 32'd1, STS_MISS, 32'd1, 4));
		dir_tab.push_back(typed_row(ACT_NONE, 32'h0, STS_MISS, 32'h0, 4));
		dir_tab.push_back(typed_row(ACT_DEQ, 32'hdead_beef, STS_DEQ, 32'h8000_0000, 3));
		dir_tab.push_back(typed_row(ACT_FIND, 32'h8000_0000, STS_MISS, 32'h8000_0000, 3));
		// Capacity lowered below the current count.
		dir_tab.push_back(cap_row(5'd1));
		dir_tab.push_back(typed_row(ACT_ENQ, 32'd5, STS_OVF, 32'd5, 3));
		dir_tab.push_back(typed_row(ACT_DEQ, 32'h0, STS_DEQ, 32'h7fff_ffff, 2));
		dir_tab.push_back(typed_row(ACT_DEQ, 32'h0, STS_DEQ, 32'hffff_ffff, 1));
		dir_tab.push_back(typed_row(ACT_DEQ, 32'h0, STS_DEQ, 32'h0, 0));
		dir_tab.push_back(typed_row(ACT_ENQ, 32'h5555_5555, STS_ENQ, 32'h5555_5555, 1));
		dir_tab.push_back(typed_row(ACT_ENQ, 32'haaaa_aaaa, STS_OVF, 32'haaaa_aaaa, 1));
		// Zero capacity makes every enqueue overflow.
		dir_tab.push_back(cap_row(5'd0));
		dir_tab.push_back(typed_row(ACT_ENQ, 32'd3, STS_OVF, 32'd3, 1));
		dir_tab.push_back(typed_row(ACT_FIND, 32'h5555_5555, STS_FOUND, 32'h5555_5555, 1));
		dir_tab.push_back(typed_row(ACT_DEQ, 32'h0, STS_DEQ, 32'h5555_5555, 0));
		dir_tab.push_back(typed_row(ACT_ENQ, 32'd3, STS_OVF, 32'd3, 0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[n]) begin
			if (dir_tab[n].wr_cap) begin
				wait_drain();
				write_cap(dir_tab[n].cap);
			end else begin
				maybe_idle(25);
				offer_beat(dir_tab[n].act, dir_tab[n].val, 1'b1, dir_tab[n].res);
			end
		end

		// Capacity above the depth saturates: fill past full, search, drain past empty.
		wait_drain();
		write_cap(5'd31);
		first_val = '0;
		last_val = '0;
		v = '0;
		for (int n = 0; n < DEPTH + 2; n++) begin
			v = $urandom;
			if (n == 0)
				first_val = v;
			if (n == DEPTH - 1)
				last_val = v;
			maybe_idle(25);
			offer_beat(ACT_ENQ, v, 1'b0, '0);
		end
		offer_beat(ACT_FIND, first_val, 1'b0, '0);
		offer_beat(ACT_FIND, last_val, 1'b0, '0);
		offer_beat(ACT_FIND, v, 1'b0, '0);
		for (int n = 0; n < DEPTH + 1; n++) begin
			maybe_idle(25);
			offer_beat(ACT_DEQ, $urandom, 1'b0, '0);
		end

		// Random phases; the count carries over from one capacity to the next.
		phase_caps = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd7, 5'd16, 5'd3, 5'd20};
		phase_caps[6] = CNT_W'($urandom_range(2, 15));
		idle_pct = 0;
		enq_w = 38;
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_drain();
			if (p == NUM_PHASES - 1)
				calm = 1'b1;
			write_cap(phase_caps[p]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// Switch between filling, draining and balanced traffic.
				if (i % 30 == 0) begin
					case ($urandom_range(0, 2))
						0:       enq_w = 60;
						1:       enq_w = 15;
						default: enq_w = 38;
					endcase
					case ($urandom_range(0, 2))
						0:       idle_pct = 0;
						1:       idle_pct = 20;
						default: idle_pct = 45;
					endcase
				end
				if (p == 0 && i == 20)
					hold_pending = 1'b1;
				r = $urandom_range(0, 99);
				if (r < 3)
					a = ACT_NONE;
				else if (r < 3 + enq_w)
					a = ACT_ENQ;
				else if (r < 78)
					a = ACT_DEQ;
				else
					a = ACT_FIND;
				// Half the find keys are taken from the entries now held, when there are any.
				if (a == ACT_FIND && mirror_count > 0 && $urandom_range(0, 1) == 1)
					v = mirror_store[(mirror_head + $urandom_range(0, mirror_count - 1)) % DEPTH];
				else if (a == ACT_DEQ)
					v = $urandom;
				else
					v = pick_value();
				maybe_idle(idle_pct);
				offer_beat(a, v, 1'b0, '0);
			end
		end

		wait_drain();
		if (mismatch_count == 0)
			$display("PASS bounded_fifo_with_key_search");
		else
			$display("FAIL bounded_fifo_with_key_search");
		$finish;
	end

endmodule

[sim.f]
hdl/bfks_pkg.sv
hdl/bfks_ctrl.sv
hdl/bfks_dp.sv
hdl/bounded_fifo_with_key_search.sv
verif/tb_bounded_fifo_with_key_search.sv
